FILE: rtl/core/xyzrgb_pkg.sv
package xyzrgb_pkg;

  // chromaticities scaled by 10000
  localparam longint CHROMA_ONE = 10000;
  localparam longint PRIM_RX    = 7355;
  localparam longint PRIM_RY    = 2645;
  localparam longint PRIM_GX    = 2658;
  localparam longint PRIM_GY    = 7243;
  localparam longint PRIM_BX    = 1669;
  localparam longint PRIM_BY    = 85;

  localparam longint PRIM_RZ = CHROMA_ONE - PRIM_RX - PRIM_RY;
  localparam longint PRIM_GZ = CHROMA_ONE - PRIM_GX - PRIM_GY;
  localparam longint PRIM_BZ = CHROMA_ONE - PRIM_BX - PRIM_BY;

  // unscaled inverse-matrix entries (cofactors)
  localparam longint RAW00 = PRIM_GY * PRIM_BZ - PRIM_BY * PRIM_GZ;
  localparam longint RAW01 = PRIM_BX * PRIM_GZ - PRIM_GX * PRIM_BZ;
  localparam longint RAW02 = PRIM_GX * PRIM_BY - PRIM_BX * PRIM_GY;
  localparam longint RAW10 = PRIM_BY * PRIM_RZ - PRIM_RY * PRIM_BZ;
  localparam longint RAW11 = PRIM_RX * PRIM_BZ - PRIM_BX * PRIM_RZ;
  localparam longint RAW12 = PRIM_BX * PRIM_RY - PRIM_RX * PRIM_BY;
  localparam longint RAW20 = PRIM_RY * PRIM_GZ - PRIM_GY * PRIM_RZ;
  localparam longint RAW21 = PRIM_GX * PRIM_RZ - PRIM_RX * PRIM_GZ;
  localparam longint RAW22 = PRIM_RX * PRIM_GY - PRIM_GX * PRIM_RY;

  // row sums: white maps to equal channels
  localparam longint WSUM0 = RAW00 + RAW01 + RAW02;
  localparam longint WSUM1 = RAW10 + RAW11 + RAW12;
  localparam longint WSUM2 = RAW20 + RAW21 + RAW22;

endpackage

FILE: rtl/core/xyz_to_rgb_gamut_normalize.sv
// XYZ to RGB conversion with gamut fix-up and normalization.
// Input channel: in_valid / in_stall with x_in, y_in, z_in (unsigned Q4.12).
// Output channel: out_valid / out_stall with red, green, blue (Q1.15,
// 2^OUT_FRAC_BITS means 1.0) and gamut_adjusted.
// A word is taken at a clock edge where valid is high and stall is low.
// Pipeline: matrix products, row sums, white add, max search, one restoring
// divide step per stage for all three channels (OUT_FRAC_BITS + 2 stages),
// then rounding into the output register.
// Throughput: one word per cycle while out_stall is low.
// Each stage holds its word while the next is full and stalled; empty
// stages keep filling, so in_stall rises only when the whole pipe is full
// and out_stall is high. Nothing is dropped or repeated.
// Reset clears all valid bits; payload registers are not reset.
module xyz_to_rgb_gamut_normalize #(
  parameter int IN_WIDTH       = 16,
  parameter int OUT_FRAC_BITS  = 15,
  parameter int COEF_FRAC_BITS = 14
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic [IN_WIDTH-1:0]      x_in,
  input  logic [IN_WIDTH-1:0]      y_in,
  input  logic [IN_WIDTH-1:0]      z_in,
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic [OUT_FRAC_BITS:0]   red,
  output logic [OUT_FRAC_BITS:0]   green,
  output logic [OUT_FRAC_BITS:0]   blue,
  output logic                     gamut_adjusted
);

  localparam int CW   = COEF_FRAC_BITS + 3;
  localparam int PW   = IN_WIDTH + 1 + CW;
  localparam int SW   = PW + 2;
  localparam int UW   = SW;
  localparam int NDIV = OUT_FRAC_BITS + 2;
  localparam int OW   = OUT_FRAC_BITS + 1;
  localparam int NS   = 5 + NDIV;
  localparam int SH   = COEF_FRAC_BITS + 1;

  localparam longint A00 = (xyzrgb_pkg::RAW00 < 0) ? -xyzrgb_pkg::RAW00 : xyzrgb_pkg::RAW00;
  localparam longint A01 = (xyzrgb_pkg::RAW01 < 0) ? -xyzrgb_pkg::RAW01 : xyzrgb_pkg::RAW01;
  localparam longint A02 = (xyzrgb_pkg::RAW02 < 0) ? -xyzrgb_pkg::RAW02 : xyzrgb_pkg::RAW02;
  localparam longint A10 = (xyzrgb_pkg::RAW10 < 0) ? -xyzrgb_pkg::RAW10 : xyzrgb_pkg::RAW10;
  localparam longint A11 = (xyzrgb_pkg::RAW11 < 0) ? -xyzrgb_pkg::RAW11 : xyzrgb_pkg::RAW11;
  localparam longint A12 = (xyzrgb_pkg::RAW12 < 0) ? -xyzrgb_pkg::RAW12 : xyzrgb_pkg::RAW12;
  localparam longint A20 = (xyzrgb_pkg::RAW20 < 0) ? -xyzrgb_pkg::RAW20 : xyzrgb_pkg::RAW20;
  localparam longint A21 = (xyzrgb_pkg::RAW21 < 0) ? -xyzrgb_pkg::RAW21 : xyzrgb_pkg::RAW21;
  localparam longint A22 = (xyzrgb_pkg::RAW22 < 0) ? -xyzrgb_pkg::RAW22 : xyzrgb_pkg::RAW22;

  // rounded to nearest, ties away from zero
  localparam longint Q00 = (((A00 <<< SH) / xyzrgb_pkg::WSUM0) + 1) >>> 1;
  localparam longint Q01 = (((A01 <<< SH) / xyzrgb_pkg::WSUM0) + 1) >>> 1;
  localparam longint Q02 = (((A02 <<< SH) / xyzrgb_pkg::WSUM0) + 1) >>> 1;
  localparam longint Q10 = (((A10 <<< SH) / xyzrgb_pkg::WSUM1) + 1) >>> 1;
  localparam longint Q11 = (((A11 <<< SH) / xyzrgb_pkg::WSUM1) + 1) >>> 1;
  localparam longint Q12 = (((A12 <<< SH) / xyzrgb_pkg::WSUM1) + 1) >>> 1;
  localparam longint Q20 = (((A20 <<< SH) / xyzrgb_pkg::WSUM2) + 1) >>> 1;
  localparam longint Q21 = (((A21 <<< SH) / xyzrgb_pkg::WSUM2) + 1) >>> 1;
  localparam longint Q22 = (((A22 <<< SH) / xyzrgb_pkg::WSUM2) + 1) >>> 1;

  localparam logic signed [CW-1:0] K00 = CW'((xyzrgb_pkg::RAW00 < 0) ? -Q00 : Q00);
  localparam logic signed [CW-1:0] K01 = CW'((xyzrgb_pkg::RAW01 < 0) ? -Q01 : Q01);
  localparam logic signed [CW-1:0] K02 = CW'((xyzrgb_pkg::RAW02 < 0) ? -Q02 : Q02);
  localparam logic signed [CW-1:0] K10 = CW'((xyzrgb_pkg::RAW10 < 0) ? -Q10 : Q10);
  localparam logic signed [CW-1:0] K11 = CW'((xyzrgb_pkg::RAW11 < 0) ? -Q11 : Q11);
  localparam logic signed [CW-1:0] K12 = CW'((xyzrgb_pkg::RAW12 < 0) ? -Q12 : Q12);
  localparam logic signed [CW-1:0] K20 = CW'((xyzrgb_pkg::RAW20 < 0) ? -Q20 : Q20);
  localparam logic signed [CW-1:0] K21 = CW'((xyzrgb_pkg::RAW21 < 0) ? -Q21 : Q21);
  localparam logic signed [CW-1:0] K22 = CW'((xyzrgb_pkg::RAW22 < 0) ? -Q22 : Q22);

  localparam logic [OW-1:0] ONE = OW'(1) << OUT_FRAC_BITS;

  logic [NS-1:0] v;
  logic [NS:0]   adv;

  always_comb begin
    adv[NS] = !out_stall;
    for (int i = NS - 1; i >= 0; i--) begin
      adv[i] = !v[i] || adv[i+1];
    end
  end

  assign in_stall  = !adv[0];
  assign out_valid = v[NS-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      if (adv[0]) begin
        v[0] <= in_valid;
      end
      for (int i = 1; i < NS; i++) begin
        if (adv[i]) begin
          v[i] <= v[i-1];
        end
      end
    end
  end

  // stage 0: nine products
  logic signed [IN_WIDTH:0] sx, sy, sz;
  logic signed [PW-1:0]     prod [3][3];

  assign sx = signed'({1'b0, x_in});
  assign sy = signed'({1'b0, y_in});
  assign sz = signed'({1'b0, z_in});

  always_ff @(posedge clk) begin
    if (adv[0]) begin
      prod[0][0] <= PW'(sx * K00);
      prod[0][1] <= PW'(sy * K01);
      prod[0][2] <= PW'(sz * K02);
      prod[1][0] <= PW'(sx * K10);
      prod[1][1] <= PW'(sy * K11);
      prod[1][2] <= PW'(sz * K12);
      prod[2][0] <= PW'(sx * K20);
      prod[2][1] <= PW'(sy * K21);
      prod[2][2] <= PW'(sz * K22);
    end
  end

  // stage 1: row sums
  logic signed [SW-1:0] chan [3];

  always_ff @(posedge clk) begin
    if (adv[1]) begin
      for (int k = 0; k < 3; k++) begin
        chan[k] <= SW'(prod[k][0]) + SW'(prod[k][1]) + SW'(prod[k][2]);
      end
    end
  end

  // stage 2: add white when a channel is negative
  logic signed [SW-1:0] lowest;
  logic signed [SW:0]   shifted [3];
  logic [UW-1:0]        adj [3];
  logic                 adj_flag;

  always_comb begin
    lowest = '0;
    for (int k = 0; k < 3; k++) begin
      if (chan[k] < lowest) begin
        lowest = chan[k];
      end
    end
    for (int k = 0; k < 3; k++) begin
      shifted[k] = (SW+1)'(chan[k]) - (SW+1)'(lowest);
    end
  end

  always_ff @(posedge clk) begin
    if (adv[2]) begin
      for (int k = 0; k < 3; k++) begin
        adj[k] <= shifted[k][UW-1:0];
      end
      adj_flag <= lowest[SW-1];
    end
  end

  // stage 3: largest channel
  logic [UW-1:0] great_c;
  logic [UW-1:0] num3 [3];
  logic [UW-1:0] den3;
  logic          flag3, zero3;

  always_comb begin
    great_c = adj[0];
    if (adj[1] > great_c) great_c = adj[1];
    if (adj[2] > great_c) great_c = adj[2];
  end

  always_ff @(posedge clk) begin
    if (adv[3]) begin
      num3  <= adj;
      den3  <= great_c;
      flag3 <= adj_flag;
      zero3 <= (great_c == '0);
    end
  end

  // divide stages: one quotient bit per stage per channel
  logic [UW:0]       rem_q  [NDIV][3];
  logic [NDIV-1:0]   quo_q  [NDIV][3];
  logic [UW-1:0]     den_q  [NDIV];
  logic              flag_q [NDIV];
  logic              zero_q [NDIV];

  for (genvar d = 0; d < NDIV; d++) begin : g_div
    logic [UW:0]     rem_in [3];
    logic [NDIV-1:0] quo_in [3];
    logic [UW-1:0]   den_in;
    logic            flag_in, zero_in;
    logic [UW:0]     diff [3];
    logic            ge [3];
    logic [UW:0]     kept [3];

    if (d == 0) begin : g_first
      always_comb begin
        for (int k = 0; k < 3; k++) begin
          rem_in[k] = {1'b0, num3[k]};
          quo_in[k] = '0;
        end
        den_in  = den3;
        flag_in = flag3;
        zero_in = zero3;
      end
    end else begin : g_next
      always_comb begin
        for (int k = 0; k < 3; k++) begin
          rem_in[k] = rem_q[d-1][k];
          quo_in[k] = quo_q[d-1][k];
        end
        den_in  = den_q[d-1];
        flag_in = flag_q[d-1];
        zero_in = zero_q[d-1];
      end
    end

    always_comb begin
      for (int k = 0; k < 3; k++) begin
        diff[k] = rem_in[k] - {1'b0, den_in};
        ge[k]   = (rem_in[k] >= {1'b0, den_in});
        kept[k] = ge[k] ? diff[k] : rem_in[k];
      end
    end

    always_ff @(posedge clk) begin
      if (adv[4+d]) begin
        for (int k = 0; k < 3; k++) begin
          rem_q[d][k] <= {kept[k][UW-1:0], 1'b0};
          quo_q[d][k] <= {quo_in[k][NDIV-2:0], ge[k]};
        end
        den_q[d]  <= den_in;
        flag_q[d] <= flag_in;
        zero_q[d] <= zero_in;
      end
    end
  end

  // output stage: round half up
  logic [NDIV:0] rnd [3];

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      rnd[k] = {1'b0, quo_q[NDIV-1][k]} + (NDIV+1)'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (adv[NS-1]) begin
      red            <= zero_q[NDIV-1] ? '0 : rnd[0][OW:1];
      green          <= zero_q[NDIV-1] ? '0 : rnd[1][OW:1];
      blue           <= zero_q[NDIV-1] ? '0 : rnd[2][OW:1];
      gamut_adjusted <= flag_q[NDIV-1];
    end
  end

  a_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (red <= ONE) && (green <= ONE) && (blue <= ONE))
    else $error("normalized channel above one");

  a_peak: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (red == ONE || green == ONE || blue == ONE ||
                   (red == '0 && green == '0 && blue == '0)))
    else $error("no channel normalized to one");

  a_full: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> (v[0] && out_valid && out_stall))
    else $error("input stalled with room in the pipe");

endmodule
